>>> hw/rtl/mips_multicycle_control_fsm_core_assert.svh
// assertion macros shared by the control unit modules
`ifndef MIPS_MULTICYCLE_CONTROL_FSM_CORE_ASSERT_SVH
`define MIPS_MULTICYCLE_CONTROL_FSM_CORE_ASSERT_SVH

// clocked assertion, checked only while out of reset
`define MMCF_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error(msg);

// clocked assertion, checked during reset as well
`define MMCF_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> hw/rtl/mmcf_pkg.sv
`default_nettype none

package mmcf_pkg;

  // control phases
  typedef enum logic [2:0] {
    PH_FETCH      = 3'd0,
    PH_WAIT_INSTR = 3'd1,
    PH_EXEC       = 3'd2,
    PH_WAIT_STORE = 3'd3,
    PH_WAIT_LOAD  = 3'd4,
    PH_HALTED     = 3'd5
  } phase_e;

  // event kinds
  localparam logic [2:0] REQ_CLOCK = 3'd0;
  localparam logic [2:0] REQ_OPCODE = 3'd1;
  localparam logic [2:0] REQ_FUNCT = 3'd2;
  localparam logic [2:0] REQ_INST_WAIT = 3'd3;
  localparam logic [2:0] REQ_DATA_WAIT = 3'd4;

  // opcodes
  localparam logic [5:0] OP_RTYPE = 6'h00;
  localparam logic [5:0] OP_J = 6'h02;
  localparam logic [5:0] OP_JAL = 6'h03;
  localparam logic [5:0] OP_BEQ = 6'h04;
  localparam logic [5:0] OP_BNE = 6'h05;
  localparam logic [5:0] OP_ADDI = 6'h08;
  localparam logic [5:0] OP_ADDIU = 6'h09;
  localparam logic [5:0] OP_ANDI = 6'h0c;
  localparam logic [5:0] OP_LW = 6'h23;
  localparam logic [5:0] OP_SW = 6'h2b;
  localparam logic [5:0] OP_HALT = 6'h3f;

  // function codes
  localparam logic [5:0] FN_SLL = 6'h00;
  localparam logic [5:0] FN_SRL = 6'h02;
  localparam logic [5:0] FN_JR = 6'h08;

  // select codes
  localparam logic [1:0] SRC2_REG = 2'd0;
  localparam logic [1:0] SRC2_IMM = 2'd1;
  localparam logic [1:0] SRC2_SHAMT = 2'd2;
  localparam logic [1:0] M2R_ALU = 2'd0;
  localparam logic [1:0] M2R_MEM = 2'd1;
  localparam logic [1:0] M2R_LINK = 2'd2;
  localparam logic [1:0] DST_RT = 2'd0;
  localparam logic [1:0] DST_RD = 2'd1;
  localparam logic [1:0] DST_LINK = 2'd2;
  localparam logic [1:0] ALUOP_ADD = 2'd0;
  localparam logic [1:0] ALUOP_CMP = 2'd1;
  localparam logic [1:0] ALUOP_FUNCT = 2'd2;
  localparam logic [1:0] ALUOP_AND = 2'd3;
  localparam logic [1:0] PCSRC_SEQ = 2'd0;
  localparam logic [1:0] PCSRC_JUMP = 2'd1;
  localparam logic [1:0] PCSRC_REG = 2'd2;

  // result item layout
  localparam int unsigned IN_W = 8;
  localparam int unsigned OUT_W = 24;
  localparam int unsigned HALT_BIT = 19;

  typedef struct packed {
    logic       branch;
    logic       alu_src_one;
    logic       reg_write;
    logic       sign_extend;
    logic       pc_enable;
    logic       inst_req;
    logic       inst_read;
    logic       data_req;
    logic       data_read;
    logic [1:0] alu_src_two;
    logic [1:0] mem_to_reg;
    logic [1:0] write_reg_dst;
    logic [1:0] alu_op_type;
    logic [1:0] pc_src;
  } ctrl_t;

  typedef struct packed {
    phase_e     phase;
    logic [5:0] opcode;
    logic [5:0] funct;
    ctrl_t      ctrl;
  } state_t;

  // pack the visible controls into one result item
  function automatic logic [OUT_W-1:0] pack_result(state_t s);
    logic [OUT_W-1:0] r;
    r = '0;
    r[0] = s.ctrl.branch;
    r[1] = s.ctrl.alu_src_one;
    r[2] = s.ctrl.reg_write;
    r[3] = s.ctrl.sign_extend;
    r[4] = s.ctrl.pc_enable;
    r[6:5] = s.ctrl.alu_src_two;
    r[8:7] = s.ctrl.mem_to_reg;
    r[10:9] = s.ctrl.write_reg_dst;
    r[12:11] = s.ctrl.alu_op_type;
    r[14:13] = s.ctrl.pc_src;
    r[18:15] = {s.ctrl.data_read, s.ctrl.data_req, s.ctrl.inst_read, s.ctrl.inst_req};
    r[HALT_BIT] = (s.phase == PH_HALTED);
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/mmcf_step.sv
`default_nettype none

module mmcf_step
  import mmcf_pkg::*;
(
  input  state_t     state_i,
  input  logic [2:0] req_i,
  input  logic [5:0] value_i,
  output state_t     state_o
);

  state_t nxt;

  // next state for one event
  always_comb begin
    nxt = state_i;
    if (state_i.phase != PH_HALTED) begin
      case (req_i)
        REQ_CLOCK: begin
          if (state_i.phase == PH_FETCH) begin
            nxt.ctrl.inst_read = 1'b1;
            nxt.ctrl.inst_req = 1'b1;
            nxt.phase = PH_WAIT_INSTR;
          end else if (state_i.phase == PH_WAIT_INSTR) begin
            nxt.ctrl.pc_enable = 1'b0;
            nxt.ctrl.reg_write = 1'b0;
          end
        end
        REQ_OPCODE: nxt.opcode = value_i;
        REQ_FUNCT: nxt.funct = value_i;
        REQ_INST_WAIT: begin
          if (value_i == 6'd0) begin
            nxt.phase = PH_EXEC;
            // decode the stored opcode, only the named signals change
            case (state_i.opcode)
              OP_RTYPE: begin
                nxt.ctrl.branch = 1'b0;
                nxt.ctrl.alu_src_one = 1'b0;
                nxt.ctrl.mem_to_reg = M2R_ALU;
                nxt.ctrl.write_reg_dst = DST_RD;
                nxt.ctrl.alu_op_type = ALUOP_FUNCT;
                if (state_i.funct == FN_JR) begin
                  nxt.ctrl.reg_write = 1'b0;
                  nxt.ctrl.pc_src = PCSRC_REG;
                end else begin
                  nxt.ctrl.reg_write = 1'b1;
                  nxt.ctrl.pc_src = PCSRC_SEQ;
                end
                nxt.ctrl.alu_src_two =
                  (state_i.funct == FN_SLL || state_i.funct == FN_SRL) ? SRC2_SHAMT : SRC2_REG;
              end
              OP_J: begin
                nxt.ctrl.reg_write = 1'b0;
                nxt.ctrl.pc_src = PCSRC_JUMP;
              end
              OP_JAL: begin
                nxt.ctrl.reg_write = 1'b1;
                nxt.ctrl.mem_to_reg = M2R_LINK;
                nxt.ctrl.write_reg_dst = DST_LINK;
                nxt.ctrl.pc_src = PCSRC_JUMP;
              end
              OP_BEQ, OP_BNE: begin
                nxt.ctrl.branch = 1'b1;
                nxt.ctrl.reg_write = 1'b0;
                nxt.ctrl.sign_extend = 1'b1;
                nxt.ctrl.alu_src_one = 1'b0;
                nxt.ctrl.alu_src_two = SRC2_REG;
                nxt.ctrl.pc_src = PCSRC_SEQ;
                nxt.ctrl.alu_op_type = ALUOP_CMP;
              end
              OP_ADDI, OP_ADDIU, OP_ANDI: begin
                nxt.ctrl.branch = 1'b0;
                nxt.ctrl.reg_write = 1'b1;
                nxt.ctrl.sign_extend = (state_i.opcode == OP_ADDI);
                nxt.ctrl.alu_src_one = 1'b0;
                nxt.ctrl.alu_src_two = SRC2_IMM;
                nxt.ctrl.mem_to_reg = M2R_ALU;
                nxt.ctrl.write_reg_dst = DST_RT;
                nxt.ctrl.pc_src = PCSRC_SEQ;
                nxt.ctrl.alu_op_type = (state_i.opcode == OP_ANDI) ? ALUOP_AND : ALUOP_ADD;
              end
              OP_SW: begin
                nxt.ctrl.branch = 1'b0;
                nxt.ctrl.reg_write = 1'b0;
                nxt.ctrl.sign_extend = 1'b1;
                nxt.ctrl.alu_src_one = 1'b0;
                nxt.ctrl.alu_src_two = SRC2_IMM;
                nxt.ctrl.pc_src = PCSRC_SEQ;
                nxt.ctrl.alu_op_type = ALUOP_ADD;
                nxt.ctrl.data_read = 1'b0;
                nxt.ctrl.data_req = 1'b1;
                nxt.phase = PH_WAIT_STORE;
              end
              OP_LW: begin
                nxt.ctrl.branch = 1'b0;
                nxt.ctrl.reg_write = 1'b1;
                nxt.ctrl.sign_extend = 1'b1;
                nxt.ctrl.alu_src_one = 1'b0;
                nxt.ctrl.alu_src_two = SRC2_IMM;
                nxt.ctrl.mem_to_reg = M2R_MEM;
                nxt.ctrl.pc_src = PCSRC_SEQ;
                nxt.ctrl.alu_op_type = ALUOP_ADD;
                nxt.ctrl.data_read = 1'b1;
                nxt.ctrl.data_req = 1'b1;
                nxt.phase = PH_WAIT_LOAD;
              end
              OP_HALT: nxt.phase = PH_HALTED;
              default: nxt.ctrl.reg_write = 1'b0;
            endcase
            if (nxt.phase == PH_EXEC) begin
              nxt.ctrl.inst_req = 1'b0;
            end
          end else begin
            nxt.phase = PH_FETCH;
            nxt.ctrl.pc_enable = 1'b1;
          end
        end
        REQ_DATA_WAIT: begin
          if (value_i == 6'd0) begin
            nxt.ctrl.data_req = 1'b0;
          end else begin
            nxt.phase = PH_EXEC;
            nxt.ctrl.inst_req = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  assign state_o = nxt;

endmodule

`default_nettype wire

>>> hw/rtl/mmcf_out_stage.sv
`default_nettype none
`include "mips_multicycle_control_fsm_core_assert.svh"

module mmcf_out_stage
  import mmcf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  logic [OUT_W-1:0] data_i,
  output logic             room_o,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [OUT_W-1:0] data_o
);

  logic             valid_q;
  logic             valid_d;
  logic [OUT_W-1:0] data_q;

  // room when empty or the held item leaves this cycle
  assign room_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o = data_q;

  `MMCF_ASSERT(a_no_load_when_full, clk_i, rst_ni, (valid_q && !ready_i) |-> !load_i, "load into a held result")
  `MMCF_ASSERT(a_load_sets_valid, clk_i, rst_ni, load_i |=> valid_q, "loaded item not presented")
  `MMCF_ASSERT(a_drain_clears, clk_i, rst_ni, (valid_q && ready_i && !load_i) |=> !valid_q, "taken item repeated")
  `MMCF_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |-> !valid_q, "result valid during reset")

endmodule

`default_nettype wire

>>> hw/rtl/mips_multicycle_control_fsm_core.sv
// Control unit for a small multicycle MIPS subset, driven by one event per item.
// Input channel s_axis: tuser carries the event kind (clock tick, opcode update,
// function update, instruction wait, data wait), tdata the opcode, function code
// or wait level. Output channel m_axis: every accepted item yields one result
// item carrying all control signals after that event.
// The result is registered and shown in the cycle after the item is accepted.
// Throughput: one item per cycle while results are taken; the event logic
// is a single combinational step between the state and result registers.
// s_axis_tready_o is high when the result register is empty or its item is
// being taken in the same cycle; while the receiver stalls a held result,
// input items wait and the state does not move.
// Reset: phase is waiting for instruction, opcode and function stores are zero,
// all controls clear except instruction request and read, no result pending.
// After the halt opcode is decoded the block reports its frozen controls with
// the halted flag for every later item.
`default_nettype none
`include "mips_multicycle_control_fsm_core_assert.svh"

module mips_multicycle_control_fsm_core
  import mmcf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [IN_W-1:0]  s_axis_tdata_i,  // event_value[5:0], zero [7:6]
  input  logic [2:0]       s_axis_tuser_i,  // req_type[2:0]
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  // branch[0], alu_src_one[1], reg_write[2], sign_extend[3], pc_enable[4],
  // alu_src_two[6:5], mem_to_reg[8:7], write_reg_dst[10:9], alu_op_type[12:11],
  // pc_src[14:13], mem_handshake[18:15], halted[19], zero [23:20]
  output logic [OUT_W-1:0] m_axis_tdata_o
);

  state_t state_q;
  state_t state_d;
  logic   accept;
  logic   room;

  assign s_axis_tready_o = room;
  assign accept = s_axis_tvalid_i && room;

  // event logic
  mmcf_step u_step (
    .state_i (state_q),
    .req_i   (s_axis_tuser_i),
    .value_i (s_axis_tdata_i[5:0]),
    .state_o (state_d)
  );

  // control state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: PH_WAIT_INSTR, opcode: '0, funct: '0,
                   ctrl: '{inst_req: 1'b1, inst_read: 1'b1, default: '0}};
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  // result register
  mmcf_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (accept),
    .data_i  (pack_result(state_d)),
    .room_o  (room),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .data_o  (m_axis_tdata_o)
  );

  `MMCF_ASSERT(a_halt_sticky, clk_i, rst_ni, (state_q.phase == PH_HALTED) |=> (state_q.phase == PH_HALTED), "left halted phase")
  `MMCF_ASSERT(a_halt_frozen, clk_i, rst_ni, (state_q.phase == PH_HALTED) |=> $stable(state_q), "state moved while halted")
  `MMCF_ASSERT(a_halt_flag, clk_i, rst_ni, m_axis_tvalid_o |-> (m_axis_tdata_o[HALT_BIT] == (state_q.phase == PH_HALTED)), "halted flag out of step with state")

endmodule

`default_nettype wire

>>> bench/mips_multicycle_control_fsm_core_tb.sv
`timescale 1ns / 1ps

module mips_multicycle_control_fsm_core_tb;
  import mmcf_pkg::*;

  // one input item: event kind and its value
  typedef struct packed {
    logic [2:0] kind;
    logic [5:0] value;
  } ctl_event_t;

  // result item laid out as on m_axis_tdata_o, msb first
  typedef struct packed {
    logic [3:0] spare;
    logic       halted;
    logic [3:0] mem_handshake;
    logic [1:0] pc_src;
    logic [1:0] alu_op_type;
    logic [1:0] write_reg_dst;
    logic [1:0] mem_to_reg;
    logic [1:0] alu_src_two;
    logic       pc_enable;
    logic       sign_extend;
    logic       reg_write;
    logic       alu_src_one;
    logic       branch;
  } ctl_word_t;

  logic             clk_i;
  logic             rst_ni;
  logic             s_axis_tvalid_i;
  logic             s_axis_tready_o;
  logic [IN_W-1:0]  s_axis_tdata_i;   // event_value[5:0], zero [7:6]
  logic [2:0]       s_axis_tuser_i;   // req_type[2:0]
  logic             m_axis_tvalid_o;
  logic             m_axis_tready_i;
  logic [OUT_W-1:0] m_axis_tdata_o;   // see ctl_word_t, branch in bit 0

  ctl_event_t event_q[$];
  ctl_word_t  expected_ctl_q[$];
  int         errors = 0;

  // shadow of the control unit
  phase_e     pred_phase;
  logic [5:0] pred_opcode;
  logic [5:0] pred_funct;
  ctrl_t      pred_ctl;

  // stimulus bookkeeping
  logic [5:0] gen_opcode = OP_RTYPE;
  bit         halt_allowed = 1'b0;

  // driver and receiver bookkeeping
  logic       in_taken = 1'b0;
  int         burst_left = 8;
  int         gap_left = 0;
  int         rx_cycle = 0;

  mips_multicycle_control_fsm_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic void reset_shadow();
    pred_phase  = PH_WAIT_INSTR;
    pred_opcode = OP_RTYPE;
    pred_funct  = FN_SLL;
    pred_ctl    = '0;
    pred_ctl.inst_req  = 1'b1;
    pred_ctl.inst_read = 1'b1;
  endfunction

  // immediate alu group: addi, addiu, andi
  function automatic void set_imm_alu(logic sext, logic [1:0] aluop);
    pred_ctl.branch        = 1'b0;
    pred_ctl.reg_write     = 1'b1;
    pred_ctl.sign_extend   = sext;
    pred_ctl.alu_src_one   = 1'b0;
    pred_ctl.alu_src_two   = SRC2_IMM;
    pred_ctl.mem_to_reg    = M2R_ALU;
    pred_ctl.write_reg_dst = DST_RT;
    pred_ctl.pc_src        = PCSRC_SEQ;
    pred_ctl.alu_op_type   = aluop;
  endfunction

  // decode the stored opcode; only the named controls move
  function automatic void decode_opcode();
    case (pred_opcode)
      OP_RTYPE: begin
        pred_ctl.branch        = 1'b0;
        pred_ctl.alu_src_one   = 1'b0;
        pred_ctl.mem_to_reg    = M2R_ALU;
        pred_ctl.write_reg_dst = DST_RD;
        pred_ctl.alu_op_type   = ALUOP_FUNCT;
        pred_ctl.reg_write     = (pred_funct != FN_JR);
        pred_ctl.pc_src        = (pred_funct == FN_JR) ? PCSRC_REG : PCSRC_SEQ;
        pred_ctl.alu_src_two   = (pred_funct == FN_SLL || pred_funct == FN_SRL) ?
                                 SRC2_SHAMT : SRC2_REG;
      end
      OP_J: begin
        pred_ctl.reg_write = 1'b0;
        pred_ctl.pc_src    = PCSRC_JUMP;
      end
      OP_JAL: begin
        pred_ctl.reg_write     = 1'b1;
        pred_ctl.mem_to_reg    = M2R_LINK;
        pred_ctl.write_reg_dst = DST_LINK;
        pred_ctl.pc_src        = PCSRC_JUMP;
      end
      OP_BEQ, OP_BNE: begin
        pred_ctl.branch      = 1'b1;
        pred_ctl.reg_write   = 1'b0;
        pred_ctl.sign_extend = 1'b1;
        pred_ctl.alu_src_one = 1'b0;
        pred_ctl.alu_src_two = SRC2_REG;
        pred_ctl.pc_src      = PCSRC_SEQ;
        pred_ctl.alu_op_type = ALUOP_CMP;
      end
      OP_ADDI:  set_imm_alu(1'b1, ALUOP_ADD);
      OP_ADDIU: set_imm_alu(1'b0, ALUOP_ADD);
      OP_ANDI:  set_imm_alu(1'b0, ALUOP_AND);
      OP_SW: begin
        pred_ctl.branch      = 1'b0;
        pred_ctl.reg_write   = 1'b0;
        pred_ctl.sign_extend = 1'b1;
        pred_ctl.alu_src_one = 1'b0;
        pred_ctl.alu_src_two = SRC2_IMM;
        pred_ctl.pc_src      = PCSRC_SEQ;
        pred_ctl.alu_op_type = ALUOP_ADD;
        pred_ctl.data_read   = 1'b0;
        pred_ctl.data_req    = 1'b1;
        pred_phase           = PH_WAIT_STORE;
      end
      OP_LW: begin
        pred_ctl.branch      = 1'b0;
        pred_ctl.reg_write   = 1'b1;
        pred_ctl.sign_extend = 1'b1;
        pred_ctl.alu_src_one = 1'b0;
        pred_ctl.alu_src_two = SRC2_IMM;
        pred_ctl.mem_to_reg  = M2R_MEM;
        pred_ctl.pc_src      = PCSRC_SEQ;
        pred_ctl.alu_op_type = ALUOP_ADD;
        pred_ctl.data_read   = 1'b1;
        pred_ctl.data_req    = 1'b1;
        pred_phase           = PH_WAIT_LOAD;
      end
      OP_HALT: pred_phase = PH_HALTED;
      default: pred_ctl.reg_write = 1'b0;
    endcase
  endfunction

  // advance the shadow by one event
  function automatic void apply_event(ctl_event_t ev);
    if (pred_phase != PH_HALTED) begin
      case (ev.kind)
        REQ_CLOCK: begin
          if (pred_phase == PH_FETCH) begin
            pred_ctl.inst_read = 1'b1;
            pred_ctl.inst_req  = 1'b1;
            pred_phase         = PH_WAIT_INSTR;
          end else if (pred_phase == PH_WAIT_INSTR) begin
            pred_ctl.pc_enable = 1'b0;
            pred_ctl.reg_write = 1'b0;
          end
        end
        REQ_OPCODE: pred_opcode = ev.value;
        REQ_FUNCT:  pred_funct = ev.value;
        REQ_INST_WAIT: begin
          if (ev.value == 6'd0) begin
            pred_phase = PH_EXEC;
            decode_opcode();
            if (pred_phase == PH_EXEC) pred_ctl.inst_req = 1'b0;
          end else begin
            pred_phase         = PH_FETCH;
            pred_ctl.pc_enable = 1'b1;
          end
        end
        REQ_DATA_WAIT: begin
          if (ev.value == 6'd0) begin
            pred_ctl.data_req = 1'b0;
          end else begin
            pred_phase        = PH_EXEC;
            pred_ctl.inst_req = 1'b0;
          end
        end
        default: ;
      endcase
    end
  endfunction

  function automatic ctl_word_t controls_now();
    ctl_word_t w;
    w               = '0;
    w.branch        = pred_ctl.branch;
    w.alu_src_one   = pred_ctl.alu_src_one;
    w.reg_write     = pred_ctl.reg_write;
    w.sign_extend   = pred_ctl.sign_extend;
    w.pc_enable     = pred_ctl.pc_enable;
    w.alu_src_two   = pred_ctl.alu_src_two;
    w.mem_to_reg    = pred_ctl.mem_to_reg;
    w.write_reg_dst = pred_ctl.write_reg_dst;
    w.alu_op_type   = pred_ctl.alu_op_type;
    w.pc_src        = pred_ctl.pc_src;
    w.mem_handshake = {pred_ctl.data_read, pred_ctl.data_req,
                       pred_ctl.inst_read, pred_ctl.inst_req};
    w.halted        = (pred_phase == PH_HALTED);
    return w;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus generation
  // ---------------------------------------------------------------------------

  // queue one item, after a replacement opcode item where needed; a halt decode is kept away until the closing part
  task automatic push_event(input logic [2:0] kind, input logic [5:0] value);
    ctl_event_t ev;
    if (kind == REQ_OPCODE) gen_opcode = value;
    if (kind == REQ_INST_WAIT && value == 6'd0 && gen_opcode == OP_HALT && !halt_allowed)
    begin
      gen_opcode = 6'($urandom_range(0, 62));
      ev.kind    = REQ_OPCODE;
      ev.value   = gen_opcode;
      event_q.push_back(ev);
    end
    ev.kind  = kind;
    ev.value = value;
    event_q.push_back(ev);
  endtask

  function automatic logic [5:0] pick_opcode();
    case ($urandom_range(0, 12))
      0:       return OP_RTYPE;
      1:       return OP_J;
      2:       return OP_JAL;
      3:       return OP_BEQ;
      4:       return OP_BNE;
      5:       return OP_ADDI;
      6:       return OP_ADDIU;
      7:       return OP_ANDI;
      8:       return OP_LW;
      9:       return OP_SW;
      10:      return OP_RTYPE;
      default: return 6'($urandom_range(0, 63));
    endcase
  endfunction

  function automatic logic [5:0] pick_funct();
    case ($urandom_range(0, 4))
      0:       return FN_SLL;
      1:       return FN_SRL;
      2:       return FN_JR;
      default: return 6'($urandom_range(0, 63));
    endcase
  endfunction

  function automatic logic [5:0] wait_high();
    return 6'($urandom_range(1, 63));
  endfunction

  // fetch, decode and, for memory ops, the data wait, with random content
  task automatic push_instruction();
    logic [5:0] op;
    op = pick_opcode();
    if ($urandom_range(0, 1) == 0) push_event(REQ_FUNCT, pick_funct());
    push_event(REQ_OPCODE, op);
    if (op == OP_RTYPE || $urandom_range(0, 3) == 0) push_event(REQ_FUNCT, pick_funct());
    push_event(REQ_CLOCK, 6'($urandom_range(0, 63)));
    push_event(REQ_INST_WAIT, wait_high());
    push_event(REQ_CLOCK, 6'd0);
    if ($urandom_range(0, 1) == 0) push_event(REQ_CLOCK, 6'($urandom_range(0, 63)));
    push_event(REQ_INST_WAIT, 6'd0);
    if (op == OP_LW || op == OP_SW) begin
      push_event(REQ_DATA_WAIT, wait_high());
      if ($urandom_range(0, 2) == 0) push_event(REQ_DATA_WAIT, wait_high());
      push_event(REQ_DATA_WAIT, 6'd0);
    end
    push_event(REQ_CLOCK, 6'd0);
  endtask

  // noise: any kind, any value, wait levels low half the time
  task automatic push_noise();
    logic [2:0] kind;
    logic [5:0] value;
    kind  = 3'($urandom_range(0, 7));
    value = 6'($urandom_range(0, 63));
    if ((kind == REQ_INST_WAIT || kind == REQ_DATA_WAIT) && $urandom_range(0, 1) == 0)
      value = 6'd0;
    push_event(kind, value);
  endtask

  // ---------------------------------------------------------------------------
  // driver: bursts of items with random gaps
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin
    ctl_event_t cur;
    if (rst_ni && !(s_axis_tvalid_i && !in_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid_i <= 1'b0;
      end else if (event_q.size() > 0) begin
        cur = event_q.pop_front();
        s_axis_tuser_i  <= cur.kind;
        s_axis_tdata_i  <= {2'b00, cur.value};
        s_axis_tvalid_i <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150) :
                                                     $urandom_range(1, 25);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // receiver: stall pattern moves through four modes in turn
  always @(negedge clk_i) begin
    rx_cycle++;
    case ((rx_cycle / 97) % 4)
      0:       m_axis_tready_i <= 1'b1;
      1:       m_axis_tready_i <= 1'($urandom_range(0, 1));
      2:       m_axis_tready_i <= (rx_cycle % 5 != 0);
      default: m_axis_tready_i <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // ---------------------------------------------------------------------------
  // monitor: check the result, then predict for the item taken this edge
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    ctl_word_t  seen;
    ctl_word_t  want;
    ctl_event_t ev;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        seen = m_axis_tdata_o;
        if (expected_ctl_q.size() == 0) begin
          $error("control word %h arrived with nothing expected", m_axis_tdata_o);
          errors++;
        end else begin
          want = expected_ctl_q.pop_front();
          check_field("branch", want.branch, seen.branch);
          check_field("alu_src_one", want.alu_src_one, seen.alu_src_one);
          check_field("reg_write", want.reg_write, seen.reg_write);
          check_field("sign_extend", want.sign_extend, seen.sign_extend);
          check_field("pc_enable", want.pc_enable, seen.pc_enable);
          check_field("alu_src_two", want.alu_src_two, seen.alu_src_two);
          check_field("mem_to_reg", want.mem_to_reg, seen.mem_to_reg);
          check_field("write_reg_dst", want.write_reg_dst, seen.write_reg_dst);
          check_field("alu_op_type", want.alu_op_type, seen.alu_op_type);
          check_field("pc_src", want.pc_src, seen.pc_src);
          check_field("mem_handshake", want.mem_handshake, seen.mem_handshake);
          check_field("halted", want.halted, seen.halted);
          check_field("spare", want.spare, seen.spare);
        end
      end
      in_taken <= s_axis_tvalid_i && s_axis_tready_o;
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        ev.kind  = s_axis_tuser_i;
        ev.value = s_axis_tdata_i[5:0];
        apply_event(ev);
        expected_ctl_q.push_back(controls_now());
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    int k;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = REQ_CLOCK;
    m_axis_tready_i = 1'b0;
    rst_ni          = 1'b0;
    reset_shadow();

    // directed: extremes, each opcode but bne and halt, data waits, undefined kind
    push_event(3'd5, 6'h3f);
    push_event(REQ_CLOCK, 6'd0);
    push_event(REQ_FUNCT, FN_SRL);
    push_event(REQ_INST_WAIT, 6'd0);
    push_event(REQ_OPCODE, OP_J);
    push_event(REQ_INST_WAIT, 6'd0);
    push_event(REQ_OPCODE, OP_JAL);
    push_event(REQ_INST_WAIT, 6'd0);
    push_event(REQ_OPCODE, OP_BEQ);
    push_event(REQ_INST_WAIT, 6'd0);
    push_event(REQ_OPCODE, OP_ADDI);
    push_event(REQ_INST_WAIT, 6'd0);
    push_event(REQ_OPCODE, OP_ADDIU);
    push_event(REQ_INST_WAIT, 6'd0);
    push_event(REQ_OPCODE, OP_ANDI);
    push_event(REQ_INST_WAIT, 6'd0);
    push_event(REQ_OPCODE, OP_SW);
    push_event(REQ_INST_WAIT, 6'd0);
    push_event(REQ_DATA_WAIT, 6'h3f);
    push_event(REQ_DATA_WAIT, 6'd0);
    push_event(REQ_OPCODE, OP_LW);
    push_event(REQ_INST_WAIT, 6'd0);
    push_event(REQ_DATA_WAIT, 6'd1);
    push_event(REQ_OPCODE, 6'h3e);
    push_event(REQ_INST_WAIT, 6'd0);
    push_event(REQ_INST_WAIT, 6'h3f);
    push_event(REQ_CLOCK, 6'd0);

    // random: mostly whole instructions, some noise
    while (event_q.size() < 640) begin
      if ($urandom_range(0, 9) < 7) push_instruction();
      else push_noise();
    end

    // halt, then every kind must only report the frozen controls
    halt_allowed = 1'b1;
    push_event(REQ_OPCODE, OP_HALT);
    push_event(REQ_INST_WAIT, 6'd0);
    for (k = 0; k < 8; k++) push_event(3'(k), 6'($urandom_range(0, 63)));
    push_event(REQ_INST_WAIT, 6'h3f);

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (event_q.size() != 0 || s_axis_tvalid_i || expected_ctl_q.size() != 0)
      @(negedge clk_i);
    repeat (10) @(posedge clk_i);

    if (expected_ctl_q.size() != 0) begin
      $error("%0d control words never arrived", expected_ctl_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // run limit, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/mmcf_pkg.sv
hw/rtl/mmcf_step.sv
hw/rtl/mmcf_out_stage.sv
hw/rtl/mips_multicycle_control_fsm_core.sv
bench/mips_multicycle_control_fsm_core_tb.sv
